// ===== hw/rtl/prt_pkg.sv =====
`default_nettype none
package prt_pkg;
  localparam int DEPTH = 16;
  localparam int SLOT_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int TAG_BITS = 16;
  localparam int ENTRY_BITS = 32 + 4 + 32 + 32 + 32 + 8 + 32 + 32;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [15:0] EXPIRY_STATUS = 16'd504;
  localparam logic [16:0] TAG_NONE = 17'h10000;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_DEAL = 3'd2;
  localparam logic [2:0] REQ_TICK = 3'd3;
  localparam logic [2:0] REQ_CANCEL = 3'd4;

  localparam logic [2:0] RES_ADD = 3'd0;
  localparam logic [2:0] RES_REMOVE = 3'd1;
  localparam logic [2:0] RES_DEAL = 3'd2;
  localparam logic [2:0] RES_EXPIRY = 3'd3;
  localparam logic [2:0] RES_CANCEL = 3'd4;
  localparam logic [2:0] RES_DONE = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [31:0] handler;
    logic [3:0] cb_kind;
    logic [31:0] context_tag;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [7:0] group_type;
    logic [31:0] extra_word;
    logic [16:0] seq_tag;
    logic [15:0] status_in;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic ok;
    logic [16:0] out_tag;
    logic [31:0] out_handler;
    logic [3:0] out_kind;
    logic [31:0] out_context;
    logic [31:0] out_user;
    logic [31:0] out_group;
    logic [7:0] out_group_type;
    logic [31:0] out_extra;
    logic [15:0] status_out;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] handler;
    logic [3:0] kind;
    logic [31:0] context_tag;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [7:0] group_type;
    logic [31:0] extra_word;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DECIDE, ST_SEND, ST_WRITE
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/prt_ram.sv =====
`default_nettype none
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/prt_cfg.sv =====
`default_nettype none
module prt_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] timeout_limit
);
  import prt_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      timeout_limit <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? timeout_limit : 32'd0;
endmodule
`default_nettype wire

// ===== hw/rtl/pending_request_tracker.sv =====
`default_nettype none
// Pending request tracker: a ring of up to DEPTH requests with wrapping tags.
// Input channel in_valid/in_stall carries one request beat (add, remove,
// deal, tick check, cancel all). Output channel out_valid/out_stall carries
// result beats; the final beat of each request has last set.
// Add, remove and deal give one result; tick and cancel give one beat per
// reported entry and then a done beat.
// Entries live in one synchronous RAM with a registered read port. A rejected
// or tagless remove or deal and an unknown request give their beat from the
// read state; add goes through the write state, and remove and a deal in the
// middle go through the decide state before their beat. A deal at the head
// gives its beat while the head advances and then drops cleared head entries.
// Tick drops cleared entries and reports expired entries from the head;
// cancel walks every live and cleared entry and reports the live ones.
// A new request is taken only after the previous one finished.
// Reset empties the ring and sets timeout_limit to 1000; the RAM is not
// cleared since only occupied entries are read.
// While out_stall is high the current beat holds and the walk waits for it.
// timeout_limit is register 0 on the APB port at address 0.
module pending_request_tracker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire prt_pkg::req_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output prt_pkg::rsp_t       out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [1:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready
);
  import prt_pkg::*;

  logic [31:0] timeout_limit;
  prt_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timeout_limit
  );

  state_t state, state_next;
  req_t req;
  logic [SLOT_BITS-1:0] head_slot;
  logic [CNT_BITS-1:0] fill_count;
  logic [TAG_BITS-1:0] last_tag;
  logic [CNT_BITS-1:0] idx;
  logic popped;

  logic we;
  logic [SLOT_BITS-1:0] waddr, raddr;
  entry_t wdata, rdata;

  prt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [TAG_BITS-1:0] head_tag, tag_dist, seq_low;
  logic tag_none, in_ring;
  logic [CNT_BITS:0] pos_sum;
  logic [SLOT_BITS-1:0] pos_slot;
  logic [31:0] age;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign head_tag = last_tag - TAG_BITS'(fill_count) + 1'b1;
  assign seq_low = req.seq_tag[TAG_BITS-1:0];
  assign tag_none = |req.seq_tag[16:TAG_BITS];
  assign tag_dist = seq_low - head_tag;
  assign in_ring = (tag_dist < TAG_BITS'(fill_count));
  assign pos_sum = (CNT_BITS+1)'(head_slot) + (CNT_BITS+1)'(idx);
  assign pos_slot = (pos_sum >= (CNT_BITS+1)'(DEPTH)) ?
                    SLOT_BITS'(pos_sum - (CNT_BITS+1)'(DEPTH)) : SLOT_BITS'(pos_sum);
  assign age = req.now - rdata.stamp;

  rsp_t rsp_next;
  logic load_rsp;
  logic [SLOT_BITS-1:0] head_next;
  logic [CNT_BITS-1:0] fill_next, idx_next;
  logic [TAG_BITS-1:0] last_next;
  logic popped_next;
  logic [CNT_BITS:0] rd_sum;

  assign rd_sum = (CNT_BITS+1)'(head_next) + (CNT_BITS+1)'(idx_next);
  assign raddr = (rd_sum >= (CNT_BITS+1)'(DEPTH)) ?
                 SLOT_BITS'(rd_sum - (CNT_BITS+1)'(DEPTH)) : SLOT_BITS'(rd_sum);

  function automatic rsp_t mk(input logic [2:0] k, input logic o,
                              input logic [16:0] t, input logic l);
    rsp_t r;
    r = '0;
    r.result_kind = k;
    r.ok = o;
    r.out_tag = t;
    r.last = l;
    return r;
  endfunction

  function automatic rsp_t with_entry(input rsp_t r0, input entry_t e);
    rsp_t r;
    r = r0;
    r.out_handler = e.handler;
    r.out_kind = e.kind;
    r.out_context = e.context_tag;
    r.out_user = e.user_id;
    r.out_group = e.group_id;
    r.out_group_type = e.group_type;
    r.out_extra = e.extra_word;
    return r;
  endfunction

  always_comb begin
    state_next = state;
    rsp_next = out_data;
    load_rsp = 1'b0;
    head_next = head_slot;
    fill_next = fill_count;
    last_next = last_tag;
    idx_next = idx;
    popped_next = popped;
    we = 1'b0;
    waddr = pos_slot;
    wdata = rdata;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DECIDE;
        idx_next = '0;
        popped_next = 1'b0;
        unique case (req.req_type)
          REQ_ADD: begin
            load_rsp = 1'b1;
            state_next = ST_SEND;
            if (req.handler == '0 || fill_count >= CNT_BITS'(DEPTH)) begin
              rsp_next = mk(RES_ADD, 1'b0, TAG_NONE, 1'b1);
            end else begin
              idx_next = fill_count;
              state_next = ST_WRITE;
              rsp_next = mk(RES_ADD, 1'b1, 17'(last_tag + 1'b1), 1'b1);
            end
          end
          REQ_REMOVE, REQ_DEAL: begin
            load_rsp = 1'b1;
            state_next = ST_SEND;
            if (tag_none) begin
              rsp_next = mk(req.req_type, 1'b1, TAG_NONE, 1'b1);
            end else if (fill_count == '0 || !in_ring) begin
              rsp_next = mk(req.req_type, 1'b0, TAG_NONE, 1'b1);
            end else begin
              load_rsp = 1'b0;
              idx_next = CNT_BITS'(tag_dist);
              state_next = ST_DECIDE;
            end
          end
          REQ_TICK, REQ_CANCEL: begin
            state_next = ST_DECIDE;
          end
          default: begin
            load_rsp = 1'b1;
            rsp_next = mk(RES_DONE, 1'b0, TAG_NONE, 1'b1);
            state_next = ST_SEND;
          end
        endcase
      end
      ST_DECIDE: begin
        // rdata holds entry at pos_slot (read issued last cycle)
        unique case (req.req_type)
          REQ_REMOVE: begin
            load_rsp = 1'b1;
            rsp_next = mk(RES_REMOVE, 1'b1, req.seq_tag, 1'b1);
            state_next = ST_SEND;
            if (idx == '0) begin
              head_next = pos_slot + 1'b1;
              if (head_slot == SLOT_BITS'(DEPTH - 1)) head_next = '0;
              fill_next = fill_count - 1'b1;
            end else begin
              we = 1'b1;
              wdata.handler = '0;
            end
          end
          REQ_DEAL: begin
            if (!popped) begin
              load_rsp = 1'b1;
              rsp_next = with_entry(mk(RES_DEAL, 1'b1, req.seq_tag, 1'b1), rdata);
              if (idx == '0) begin
                head_next = (head_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : head_slot + 1'b1;
                fill_next = fill_count - 1'b1;
                popped_next = 1'b1;
                // next cycle re-reads head: use ST_WRITE as wait
                state_next = ST_WRITE;
              end else begin
                we = 1'b1;
                wdata.handler = '0;
                state_next = ST_SEND;
              end
            end else if (fill_count != '0 && rdata.handler == '0) begin
              head_next = (head_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : head_slot + 1'b1;
              fill_next = fill_count - 1'b1;
              state_next = ST_WRITE;
            end else begin
              state_next = ST_SEND;
            end
          end
          REQ_TICK: begin
            if (fill_count == '0) begin
              load_rsp = 1'b1;
              rsp_next = mk(RES_DONE, 1'b1, TAG_NONE, 1'b1);
              state_next = ST_SEND;
            end else if (rdata.handler == '0) begin
              head_next = (head_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : head_slot + 1'b1;
              fill_next = fill_count - 1'b1;
              state_next = ST_WRITE;
            end else if (age > timeout_limit) begin
              load_rsp = 1'b1;
              rsp_next = with_entry(mk(RES_EXPIRY, 1'b1, 17'(head_tag), 1'b0), rdata);
              rsp_next.status_out = EXPIRY_STATUS;
              head_next = (head_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : head_slot + 1'b1;
              fill_next = fill_count - 1'b1;
              state_next = ST_SEND;
            end else begin
              load_rsp = 1'b1;
              rsp_next = mk(RES_DONE, 1'b1, TAG_NONE, 1'b1);
              state_next = ST_SEND;
            end
          end
          REQ_CANCEL: begin
            if (idx >= fill_count) begin
              load_rsp = 1'b1;
              rsp_next = mk(RES_DONE, 1'b1, TAG_NONE, 1'b1);
              state_next = ST_SEND;
            end else if (rdata.handler != '0) begin
              load_rsp = 1'b1;
              rsp_next = with_entry(mk(RES_CANCEL, 1'b1,
                                       17'(head_tag + TAG_BITS'(idx)), 1'b0), rdata);
              rsp_next.status_out = req.status_in;
              idx_next = idx + 1'b1;
              state_next = ST_SEND;
            end else begin
              idx_next = idx + 1'b1;
              state_next = ST_WRITE;
            end
          end
          default: begin
            state_next = ST_SEND;
          end
        endcase
      end
      ST_SEND: begin
        // a beat already taken while the head was being advanced counts as sent
        if (!out_valid || !out_stall) begin
          state_next = out_data.last ? ST_IDLE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        // add write-back, or read wait before re-deciding
        if (req.req_type == REQ_ADD && out_data.ok && !popped) begin
          we = 1'b1;
          wdata.handler = req.handler;
          wdata.kind = req.cb_kind;
          wdata.context_tag = req.context_tag;
          wdata.user_id = req.user_id;
          wdata.group_id = req.group_id;
          wdata.group_type = req.group_type;
          wdata.extra_word = req.extra_word;
          wdata.stamp = req.now;
          last_next = last_tag + 1'b1;
          fill_next = fill_count + 1'b1;
          popped_next = 1'b1;
          state_next = ST_SEND;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head_slot <= '0;
      fill_count <= '0;
      last_tag <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      popped <= 1'b0;
    end else begin
      state <= state_next;
      head_slot <= head_next;
      fill_count <= fill_next;
      last_tag <= last_next;
      idx <= idx_next;
      popped <= popped_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_rsp && !(req.req_type == REQ_ADD && rsp_next.ok)) begin
        out_valid <= 1'b1;
      end else if (state == ST_WRITE && state_next == ST_SEND) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (load_rsp) begin
      out_data <= rsp_next;
    end
  end
endmodule
`default_nettype wire
